// ===== hw/rtl/ogpc_pkg.sv =====
// Shared types, codes and the CRC step of the Ogg page checker.
package ogpc_pkg;

  localparam int unsigned MaxSegmentsDef = 255;
  localparam int unsigned OutqDepth      = 4;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_MAGIC   = 4'd1;
  localparam logic [3:0] ST_VERSION = 4'd2;
  localparam logic [3:0] ST_CONT    = 4'd3;
  localparam logic [3:0] ST_BOS     = 4'd4;
  localparam logic [3:0] ST_SEQ     = 4'd5;
  localparam logic [3:0] ST_SPAN    = 4'd6;
  localparam logic [3:0] ST_TRUNC   = 4'd7;
  localparam logic [3:0] ST_EOS     = 4'd8;
  localparam logic [3:0] ST_CRC     = 4'd9;

  localparam logic [7:0]  FLAG_CONT = 8'h01;
  localparam logic [7:0]  FLAG_BOS  = 8'h02;
  localparam logic [7:0]  FLAG_EOS  = 8'h04;
  localparam logic [31:0] MAGIC_OGGS = 32'h5367674F;
  localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
  localparam logic [7:0]  LACE_FULL = 8'd255;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        end_of_packet;
    logic [3:0]  status;
    logic [63:0] granule_pos;
    logic [31:0] stream_serial;
    logic [31:0] page_sequence;
    logic [7:0]  packet_count;
    logic [15:0] body_len;
    logic        last_of_run;
  } res_t;

  // One byte of the MSB-first CRC-32, init handled by caller.
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ogpc_outq.sv =====
// Result queue: takes up to two items a cycle, hands out one unless stalled.
module ogpc_outq
  import ogpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  logic push1_i,
  input  res_t data0_i,
  input  res_t data1_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output res_t data_o
);
  localparam int unsigned PW = $clog2(OutqDepth);
  localparam int unsigned CW = $clog2(OutqDepth + 1);

  res_t          q_mem [OutqDepth];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = cnt_q != '0;
  assign data_o  = q_mem[rp_q];
  assign full_o  = cnt_q > CW'(OutqDepth - 2);

  always_comb begin
    wp_d  = wp_q + PW'(push0_i) + PW'(push1_i);
    rp_d  = rp_q + PW'(pop);
    cnt_d = cnt_q + CW'(push0_i) + CW'(push1_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      q_mem[wp_q] <= data0_i;
    end
    if (push1_i) begin
      q_mem[wp_q + PW'(1)] <= data1_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(OutqDepth)) else $error("result queue overflow");
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i) else $error("second push without first");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> $past(cnt_q) != '0) else $error("full with empty queue");

endmodule

// ===== hw/rtl/ogg_page_checker_top.sv =====
// Top level of the byte-serial Ogg page checker.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  in      | in_valid_i/in_stall_o | data_byte_i, last_byte_i
//  out     | out_valid_o/out_stall_i | kind_o ... last_of_run_o (one item)
//
// One input byte per cycle unless stalled; a byte yields zero, one or two
// items (payload then page status), drained one per unstalled cycle via a
// four-entry queue. Input stalls only when it has fewer than two free slots.
// The lacing table lives in a one-port-write, registered-read RAM; data
// bytes walk it by a prefetched pointer, with write-to-read forwarding.
// Reset is asynchronous, active low; no clearing pass is needed.
module ogg_page_checker_top
  import ogpc_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        end_of_packet_o,
  output logic [3:0]  status_o,
  output logic [63:0] granule_pos_o,
  output logic [31:0] stream_serial_o,
  output logic [31:0] page_sequence_o,
  output logic [7:0]  packet_count_o,
  output logic [15:0] body_len_o,
  output logic        last_of_run_o
);
  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LACING = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  logic [1:0]    phase_q, phase_d;
  logic [4:0]    hcnt_q, hcnt_d;
  logic [31:0]   magic_q, magic_d;
  logic [7:0]    ver_q, ver_d, type_q, type_d;
  logic [63:0]   gran_q, gran_d;
  logic [31:0]   serial_q, serial_d, seq_q, seq_d;
  logic [31:0]   scrc_q, scrc_d, crc_q, crc_d;
  logic [31:0]   expseq_q, expseq_d;
  logic [7:0]    segtot_q, segtot_d, lcnt_q, lcnt_d;
  logic [7:0]    pkts_q, pkts_d, left_q, left_d;
  logic [15:0]   plen_q, plen_d, dcnt_q, dcnt_d;
  logic          prev255_q, prev255_d, ceop_q, ceop_d, err_q, err_d;
  logic [AW-1:0] wp_q, wp_d, idx_q, idx_d;

  // lacing RAM: {length, ends packet}, nonzero segments only
  logic [8:0]    lac_mem [MAX_SEGMENTS];
  logic [8:0]    rdat_q, fwd_dat_q, rdat, wdat;
  logic          fwd_q, we;
  logic [AW-1:0] wa;

  logic       in_acc, last, do_pay, do_rep, full_rst, new_pg, eop_f, page_done;
  logic [7:0] b, len_now;
  logic [3:0] code, hdr_code;
  logic [2:0] hsel;
  res_t       pay_r, rep_r;
  logic       q_full;
  res_t       q_out;

  assign in_acc     = in_valid_i && !q_full;
  assign in_stall_o = q_full;
  assign b          = data_byte_i;
  assign last       = last_byte_i;
  assign rdat       = fwd_q ? fwd_dat_q : rdat_q;

  always_comb begin
    hdr_code = ST_OK;
    if (magic_q != MAGIC_OGGS) begin
      hdr_code = ST_MAGIC;
    end else if (ver_q != 8'd0) begin
      hdr_code = ST_VERSION;
    end else if ((type_q & FLAG_CONT) != 8'd0) begin
      hdr_code = ST_CONT;
    end else if (((type_q & FLAG_BOS) != 8'd0) != (seq_q == 32'd0)) begin
      hdr_code = ST_BOS;
    end else if (seq_q != expseq_q) begin
      hdr_code = ST_SEQ;
    end
  end

  always_comb begin
    phase_d = phase_q;   hcnt_d = hcnt_q;     magic_d = magic_q;
    ver_d = ver_q;       type_d = type_q;     gran_d = gran_q;
    serial_d = serial_q; seq_d = seq_q;       scrc_d = scrc_q;
    crc_d = crc_q;       expseq_d = expseq_q; segtot_d = segtot_q;
    lcnt_d = lcnt_q;     pkts_d = pkts_q;     left_d = left_q;
    plen_d = plen_q;     dcnt_d = dcnt_q;     prev255_d = prev255_q;
    ceop_d = ceop_q;     err_d = err_q;       wp_d = wp_q;
    idx_d = idx_q;
    we = 1'b0; wa = wp_q; wdat = '0;
    do_pay = 1'b0; do_rep = 1'b0; code = ST_OK; page_done = 1'b0;
    full_rst = 1'b0; new_pg = 1'b0; eop_f = 1'b0; len_now = '0;
    hsel = '0;

    if (in_acc && err_q) begin
      full_rst = last;
    end else if (in_acc) begin
      case (phase_q)
        PH_HEADER: begin
          crc_d = crc_step(crc_q, (hcnt_q >= 5'd22 && hcnt_q <= 5'd25) ? 8'd0 : b);
          if (hcnt_q < 5'd4) begin
            magic_d[8*hcnt_q[1:0] +: 8] = b;
          end else if (hcnt_q == 5'd4) begin
            ver_d = b;
          end else if (hcnt_q == 5'd5) begin
            type_d = b;
          end else if (hcnt_q < 5'd14) begin
            hsel = 3'(hcnt_q - 5'd6);
            gran_d[8*hsel +: 8] = b;
          end else if (hcnt_q < 5'd22) begin
            hsel = 3'(hcnt_q - 5'd14);
            if (hsel[2]) begin
              seq_d[8*hsel[1:0] +: 8] = b;
            end else begin
              serial_d[8*hsel[1:0] +: 8] = b;
            end
          end else if (hcnt_q < 5'd26) begin
            hsel = 3'(hcnt_q - 5'd22);
            scrc_d[8*hsel[1:0] +: 8] = b;
          end
          if (hcnt_q < 5'd26) begin
            hcnt_d = hcnt_q + 5'd1;
            if (last) begin
              do_rep = 1'b1; code = ST_TRUNC;
            end
          end else begin
            segtot_d = b;
            code = hdr_code;
            if (code == ST_OK && 9'(b) > 9'(MAX_SEGMENTS)) begin
              code = ST_SPAN;
            end
            if (code != ST_OK) begin
              do_rep = 1'b1;
            end else begin
              expseq_d = expseq_q + 32'd1;
              if (b == 8'd0) begin
                page_done = 1'b1;
              end else begin
                phase_d = PH_LACING;
                lcnt_d = '0;
                if (last) begin
                  do_rep = 1'b1; code = ST_TRUNC;
                end
              end
            end
          end
        end
        PH_LACING: begin
          crc_d = crc_step(crc_q, b);
          if (b != 8'd0) begin
            we = 1'b1; wa = wp_q; wdat = {b, b != LACE_FULL};
            wp_d = wp_q + AW'(1);
          end else if (prev255_q) begin
            // zero-length slot ends the packet of the full segment before it
            we = 1'b1; wa = wp_q - AW'(1); wdat = {LACE_FULL, 1'b1};
          end
          prev255_d = b == LACE_FULL;
          if (b != LACE_FULL) begin
            pkts_d = pkts_q + 8'd1;
          end
          plen_d = plen_q + 16'(b);
          if (9'(lcnt_q) + 9'd1 >= 9'(segtot_q)) begin
            if (b == LACE_FULL) begin
              do_rep = 1'b1; code = ST_SPAN;
            end else if (plen_d == 16'd0) begin
              page_done = 1'b1;
            end else begin
              phase_d = PH_DATA;
              left_d = '0;
              dcnt_d = '0;
              if (last) begin
                do_rep = 1'b1; code = ST_TRUNC;
              end
            end
          end else begin
            lcnt_d = lcnt_q + 8'd1;
            if (last) begin
              do_rep = 1'b1; code = ST_TRUNC;
            end
          end
        end
        PH_DATA: begin
          crc_d = crc_step(crc_q, b);
          if (left_q == 8'd0) begin
            len_now = rdat[8:1];
            eop_f   = rdat[0];
            idx_d   = idx_q + AW'(1);
          end else begin
            len_now = left_q;
            eop_f   = ceop_q;
          end
          left_d = len_now - 8'd1;
          ceop_d = eop_f;
          do_pay = 1'b1;
          dcnt_d = dcnt_q + 16'd1;
          if (dcnt_d == plen_q) begin
            page_done = 1'b1;
          end else if (last) begin
            do_rep = 1'b1; code = ST_TRUNC;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
      if (page_done) begin
        do_rep = 1'b1;
        if (((type_q & FLAG_EOS) != 8'd0) != last) begin
          code = ST_EOS;
        end else if (crc_d != scrc_q) begin
          code = ST_CRC;
        end else begin
          code = ST_OK;
        end
      end
      if (do_rep) begin
        if (last) begin
          full_rst = 1'b1;
        end else if (code != ST_OK) begin
          err_d = 1'b1;
        end else begin
          new_pg = 1'b1;
        end
      end
    end

    pay_r = '0;
    pay_r.payload_byte  = b;
    pay_r.end_of_packet = (left_d == 8'd0) && eop_f;
    pay_r.last_of_run   = !do_rep;
    rep_r = '0;
    rep_r.kind          = 1'b1;
    rep_r.status        = code;
    rep_r.granule_pos   = gran_d;
    rep_r.stream_serial = serial_d;
    rep_r.page_sequence = seq_d;
    rep_r.packet_count  = pkts_d;
    rep_r.body_len      = plen_d;
    rep_r.last_of_run   = 1'b1;

    if (full_rst || new_pg) begin
      phase_d = PH_HEADER; hcnt_d = '0; magic_d = '0; ver_d = '0; type_d = '0;
      gran_d = '0; serial_d = '0; seq_d = '0; scrc_d = '0; crc_d = '0;
      segtot_d = '0; lcnt_d = '0; pkts_d = '0; left_d = '0; plen_d = '0;
      dcnt_d = '0; prev255_d = 1'b0; ceop_d = 1'b0; wp_d = '0; idx_d = '0;
    end
    if (full_rst) begin
      expseq_d = '0;
      err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hcnt_q <= '0; magic_q <= '0; ver_q <= '0;
      type_q <= '0; gran_q <= '0; serial_q <= '0; seq_q <= '0; scrc_q <= '0;
      crc_q <= '0; expseq_q <= '0; segtot_q <= '0; lcnt_q <= '0;
      pkts_q <= '0; left_q <= '0; plen_q <= '0; dcnt_q <= '0;
      prev255_q <= 1'b0; ceop_q <= 1'b0; err_q <= 1'b0; wp_q <= '0;
      idx_q <= '0; fwd_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; magic_q <= magic_d; ver_q <= ver_d;
      type_q <= type_d; gran_q <= gran_d; serial_q <= serial_d; seq_q <= seq_d;
      scrc_q <= scrc_d; crc_q <= crc_d; expseq_q <= expseq_d;
      segtot_q <= segtot_d; lcnt_q <= lcnt_d; pkts_q <= pkts_d;
      left_q <= left_d; plen_q <= plen_d; dcnt_q <= dcnt_d;
      prev255_q <= prev255_d; ceop_q <= ceop_d; err_q <= err_d; wp_q <= wp_d;
      idx_q <= idx_d; fwd_q <= we && (wa == idx_d);
    end
  end

  // lacing RAM, read every cycle at the next pointer
  always_ff @(posedge clk_i) begin
    if (we) begin
      lac_mem[wa] <= wdat;
    end
    rdat_q    <= lac_mem[idx_d];
    fwd_dat_q <= wdat;
  end

  ogpc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (do_pay || do_rep),
    .push1_i (do_pay && do_rep),
    .data0_i (do_pay ? pay_r : rep_r),
    .data1_i (rep_r),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (q_out)
  );

  assign kind_o          = q_out.kind;
  assign payload_byte_o  = q_out.payload_byte;
  assign end_of_packet_o = q_out.end_of_packet;
  assign status_o        = q_out.status;
  assign granule_pos_o   = q_out.granule_pos;
  assign stream_serial_o = q_out.stream_serial;
  assign page_sequence_o = q_out.page_sequence;
  assign packet_count_o  = q_out.packet_count;
  assign body_len_o      = q_out.body_len;
  assign last_of_run_o   = q_out.last_of_run;

  a_silent_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && err_q) |-> !(do_pay || do_rep)) else $error("item during error hold");
  a_data_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> plen_q != 16'd0) else $error("data phase, empty page");
  a_entry_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !err_q && phase_q == PH_DATA && left_q == 8'd0) |-> rdat[8:1] != 8'd0)
    else $error("zero lacing entry fetched");
  a_err_after_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_rep && code != ST_OK && !last) |=> err_q) else $error("error not held");

endmodule

// ===== tb/ogg_page_checker_top_tb.sv =====
// Testbench of the Ogg page checker: generated streams, a predictor and an in-order output check.
module ogg_page_checker_top_tb
  import ogpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SegMax     = 255;
  localparam int unsigned ItemTarget = 1650;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffLen = 300;

  typedef enum int {
    MD_GOOD, MD_MAGIC, MD_VER, MD_CONT, MD_BOS, MD_SEQ,
    MD_SPAN, MD_TRUNC, MD_EOS, MD_CRC, MD_NOISE, MD_COUNT
  } stream_mode_e;

  // One row of the directed table; typed expectation only where chk is set.
  typedef struct {
    logic [7:0] d;
    logic       l;
    logic       chk;
    logic [3:0] st;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  payload_byte_o;
  logic        end_of_packet_o;
  logic [3:0]  status_o;
  logic [63:0] granule_pos_o;
  logic [31:0] stream_serial_o;
  logic [31:0] page_sequence_o;
  logic [7:0]  packet_count_o;
  logic [15:0] body_len_o;
  logic        last_of_run_o;

  ogg_page_checker_top dut (.*);

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the page walker.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {PW_HEADER, PW_LACING, PW_DATA} page_walk_e;

  page_walk_e  pw_phase;
  int unsigned pw_hcnt;
  logic [63:0] pw_granule;
  logic [63:0] pw_serseq;     // serial in low half, sequence in high half
  logic [63:0] pw_ident;      // magic, version <<32, flags <<40
  logic [31:0] pw_crc_stored;
  logic [31:0] pw_crc_run;
  logic [31:0] pw_seq_next;
  logic [7:0]  pw_lace [SegMax];
  int unsigned pw_seg_idx, pw_seg_tot, pw_seg_left;
  int unsigned pw_packets, pw_length, pw_data_cnt;
  logic        pw_hold;

  res_t page_results_q[$];   // results expected from the block, oldest first
  int   fail_cnt = 0;

  function automatic logic [31:0] ogg_crc_byte(logic [31:0] c, logic [7:0] b);
    c ^= {b, 24'd0};
    for (int k = 0; k < 8; k++) c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    return c;
  endfunction

  function automatic void walker_new_page();
    pw_phase = PW_HEADER;
    pw_hcnt = 0;
    pw_granule = '0; pw_serseq = '0; pw_ident = '0;
    pw_crc_stored = '0; pw_crc_run = '0;
    pw_seg_idx = 0; pw_seg_tot = 0; pw_seg_left = 0;
    pw_packets = 0; pw_length = 0; pw_data_cnt = 0;
  endfunction

  function automatic void walker_reset();
    walker_new_page();
    pw_seq_next = '0;
    foreach (pw_lace[i]) pw_lace[i] = '0;
    pw_hold = 1'b0;
  endfunction

  function automatic void walker_report(logic [3:0] code, logic last);
    res_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = code;
    r.granule_pos = pw_granule;
    r.stream_serial = pw_serseq[31:0];
    r.page_sequence = pw_serseq[63:32];
    r.packet_count = pw_packets[7:0];
    r.body_len = pw_length[15:0];
    page_results_q.insert(page_results_q.size(), r);
    if (last) walker_reset();
    else if (code != ST_OK) pw_hold = 1'b1;
    else walker_new_page();
  endfunction

  function automatic void walker_close_page(logic last);
    logic [7:0] fl;
    logic [3:0] code;
    fl = pw_ident[47:40];
    code = ST_OK;
    if ((fl[2] != 1'b0) != last) code = ST_EOS;
    else if (pw_crc_run != pw_crc_stored) code = ST_CRC;
    walker_report(code, last);
  endfunction

  function automatic logic [3:0] walker_header_code();
    logic [7:0]  fl;
    logic [31:0] sq;
    fl = pw_ident[47:40];
    sq = pw_serseq[63:32];
    if (pw_ident[31:0] != MAGIC_OGGS) return ST_MAGIC;
    if (pw_ident[39:32] != 8'd0) return ST_VERSION;
    if ((fl & FLAG_CONT) != 0) return ST_CONT;
    if (((fl & FLAG_BOS) != 0) != (sq == 0)) return ST_BOS;
    if (sq != pw_seq_next) return ST_SEQ;
    return ST_OK;
  endfunction

  // Advance the walker by one accepted byte, queueing what it produces.
  function automatic void walker_step(logic [7:0] b, logic last);
    int          n0;
    int unsigned h, lac;
    logic [3:0]  code;
    logic        eop;
    res_t        r;
    n0 = page_results_q.size();
    if (pw_hold) begin
      if (last) walker_reset();
      return;
    end
    case (pw_phase)
      PW_HEADER: begin
        h = pw_hcnt;
        pw_crc_run = ogg_crc_byte(pw_crc_run, (h >= 22 && h <= 25) ? 8'd0 : b);
        if (h < 4) pw_ident |= 64'(b) << (8 * h);
        else if (h == 4) pw_ident |= 64'(b) << 32;
        else if (h == 5) pw_ident |= 64'(b) << 40;
        else if (h < 14) pw_granule |= 64'(b) << (8 * (h - 6));
        else if (h < 22) pw_serseq |= 64'(b) << (8 * (h - 14));
        else if (h < 26) pw_crc_stored |= 32'(b) << (8 * (h - 22));
        if (h < 26) begin
          pw_hcnt = h + 1;
          if (last) walker_report(ST_TRUNC, 1'b1);
        end else begin
          code = walker_header_code();
          pw_seg_tot = b;
          if (code == ST_OK && b > SegMax) code = ST_SPAN;
          if (code != ST_OK) walker_report(code, last);
          else begin
            pw_seq_next++;
            if (b == 0) walker_close_page(last);
            else begin
              pw_phase = PW_LACING;
              pw_seg_idx = 0;
              if (last) walker_report(ST_TRUNC, 1'b1);
            end
          end
        end
      end
      PW_LACING: begin
        pw_crc_run = ogg_crc_byte(pw_crc_run, b);
        if (pw_seg_idx < SegMax) pw_lace[pw_seg_idx] = b;
        if (b < LACE_FULL) pw_packets++;
        pw_length += b;
        if (pw_seg_idx + 1 >= pw_seg_tot) begin
          if (b == LACE_FULL) walker_report(ST_SPAN, last);
          else if (pw_length == 0) walker_close_page(last);
          else begin
            pw_phase = PW_DATA;
            pw_seg_idx = 0; pw_seg_left = 0; pw_data_cnt = 0;
            if (last) walker_report(ST_TRUNC, 1'b1);
          end
        end else begin
          pw_seg_idx++;
          if (last) walker_report(ST_TRUNC, 1'b1);
        end
      end
      default: begin
        lac = 0;
        eop = 1'b0;
        pw_crc_run = ogg_crc_byte(pw_crc_run, b);
        if (pw_seg_left == 0) begin
          while (pw_seg_idx < pw_seg_tot && pw_seg_idx < SegMax && pw_lace[pw_seg_idx] == 0)
            pw_seg_idx++;
          if (pw_seg_idx < pw_seg_tot && pw_seg_idx < SegMax) pw_seg_left = pw_lace[pw_seg_idx];
        end
        if (pw_seg_idx < pw_seg_tot && pw_seg_idx < SegMax) lac = pw_lace[pw_seg_idx];
        if (pw_seg_left > 0) begin
          pw_seg_left--;
          if (pw_seg_left == 0) begin
            // a full segment closes a packet only when a zero-length one follows
            if (lac < 255) eop = 1'b1;
            else if (pw_seg_idx + 1 < pw_seg_tot && pw_seg_idx + 1 < SegMax &&
                     pw_lace[pw_seg_idx + 1] == 0) eop = 1'b1;
            pw_seg_idx++;
          end
        end
        pw_data_cnt++;
        r = '0;
        r.payload_byte = b;
        r.end_of_packet = eop;
        page_results_q.insert(page_results_q.size(), r);
        if (pw_data_cnt >= pw_length) walker_close_page(last);
        else if (last) walker_report(ST_TRUNC, 1'b1);
      end
    endcase
    if (page_results_q.size() > n0) page_results_q[$].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream builder
  // ---------------------------------------------------------------------------
  logic [7:0] stim_byte_q[$];
  logic       stim_last_q[$];
  dir_row_t   dir_rows[$];
  logic       dir_chk_q[$];
  logic [3:0] dir_st_q[$];

  task automatic build_page(input logic [31:0] seq, input logic eos_page,
                            input stream_mode_e md, ref logic [7:0] pg[$]);
    logic [7:0]  flags, lv, lace[$];
    logic [31:0] crc, sq;
    logic [63:0] gran;
    int unsigned nseg, total, k;
    pg.delete();
    sq = seq;
    flags = 8'($urandom) & 8'hF8;
    if (seq == 0) flags |= FLAG_BOS;
    if (eos_page) flags |= FLAG_EOS;
    if (md == MD_CONT) flags |= FLAG_CONT;
    if (md == MD_BOS) flags ^= FLAG_BOS;
    if (md == MD_EOS) flags ^= FLAG_EOS;
    if (md == MD_SEQ) sq = seq + $urandom_range(1, 3);
    gran = {$urandom, $urandom};
    pg = '{8'h4F, 8'h67, 8'h67, 8'h53};
    if (md == MD_MAGIC) pg[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    pg.insert(pg.size(), md == MD_VER ? 8'($urandom_range(1, 255)) : 8'd0);
    pg.insert(pg.size(), flags);
    for (k = 0; k < 8; k++) pg.insert(pg.size(), gran[8*k +: 8]);
    crc = $urandom;
    for (k = 0; k < 4; k++) pg.insert(pg.size(), crc[8*k +: 8]);
    for (k = 0; k < 4; k++) pg.insert(pg.size(), sq[8*k +: 8]);
    for (k = 0; k < 4; k++) pg.insert(pg.size(), 8'd0);
    // mostly short tables; now and then a full one of mostly empty slots
    nseg = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 5);
    if (md == MD_SPAN && nseg == 0) nseg = 1;
    total = 0;
    for (k = 0; k < nseg; k++) begin
      if (nseg == 255) begin
        lv = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;
      end else begin
        case ($urandom_range(0, 29))
          0:                lv = 8'd255;
          1, 2, 3, 4, 5, 6: lv = 8'd0;
          default:          lv = 8'($urandom_range(1, 12));
        endcase
      end
      lace.insert(lace.size(), lv);
    end
    if (nseg > 0) begin
      if (md == MD_SPAN) lace[nseg-1] = LACE_FULL;
      else if (lace[nseg-1] == LACE_FULL) lace[nseg-1] = 8'($urandom_range(0, 40));
    end
    pg.insert(pg.size(), 8'(nseg));
    foreach (lace[i]) begin
      pg.insert(pg.size(), lace[i]);
      total += lace[i];
    end
    for (k = 0; k < total; k++) pg.insert(pg.size(), 8'($urandom));
    crc = '0;
    foreach (pg[i]) crc = ogg_crc_byte(crc, pg[i]);
    if (md == MD_CRC) crc ^= 32'(1) << $urandom_range(0, 31);
    for (k = 0; k < 4; k++) pg[22 + k] = crc[8*k +: 8];
  endtask

  // One stream: a run of pages, possibly one broken, or random noise bytes; always closed by last_byte.
  task automatic queue_stream(input stream_mode_e md);
    logic [7:0]  pg[$], st[$];
    int unsigned npg, bad, cut;
    if (md == MD_NOISE) begin
      repeat ($urandom_range(1, 40)) st.insert(st.size(), 8'($urandom));
    end else begin
      npg = $urandom_range(1, 2);
      bad = $urandom_range(0, npg - 1);
      for (int p = 0; p < npg; p++) begin
        build_page(p, p == npg - 1, (p == bad) ? md : MD_GOOD, pg);
        foreach (pg[i]) st.insert(st.size(), pg[i]);
      end
      if (md == MD_TRUNC) begin
        cut = $urandom_range(1, st.size() - 1);
        while (st.size() > cut) void'(st.pop_back());
      end
    end
    foreach (st[i]) begin
      stim_byte_q.insert(stim_byte_q.size(), st[i]);
      stim_last_q.insert(stim_last_q.size(), i == st.size() - 1);
      dir_chk_q.insert(dir_chk_q.size(), 1'b0);
      dir_st_q.insert(dir_st_q.size(), ST_OK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pacing: three idling regimes keyed to how far the input has got.
  // ---------------------------------------------------------------------------
  int unsigned accepted_cnt = 0;
  int unsigned total_items = 0;
  int unsigned send_idle_pct, recv_idle_pct;

  always_comb begin
    if (accepted_cnt < total_items / 3) begin
      send_idle_pct = 24; recv_idle_pct = 63;
    end else if (accepted_cnt < 2 * total_items / 3) begin
      send_idle_pct = 63; recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;  recv_idle_pct = 0;
    end
  end

  // Sender: hold a stalled item, else offer the next one unless idling.
  logic stim_done = 1'b0;
  initial begin
    logic        chk;
    logic [3:0]  st;
    int          n0;
    res_t        r;
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        chk = dir_chk_q.pop_front();
        st = dir_st_q.pop_front();
        n0 = page_results_q.size();
        walker_step(data_byte_i, last_byte_i);
        accepted_cnt++;
        // typed rows: a lone truncation report with empty header fields
        if (chk) begin
          r = '0;
          r.kind = 1'b1;
          r.status = st;
          r.last_of_run = 1'b1;
          if (page_results_q.size() != n0 + 1 || page_results_q[$] != r) begin
            $error("directed row: expected status %0d, predictor disagrees", st);
            fail_cnt++;
          end
        end
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (stim_byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          data_byte_i <= stim_byte_q.pop_front();
          last_byte_i <= stim_last_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (stim_byte_q.size() == 0) stim_done = 1'b1;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block fills and backs up.
  initial begin
    int unsigned hold_left;
    logic        held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && accepted_cnt >= 300) begin
        held = 1'b1;
        hold_left = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fail_cnt++;
    end
  endtask

  // Output check against the oldest expectation.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (page_results_q.size() == 0) begin
        $error("unexpected output item: kind %0b status %0d", kind_o, status_o);
        fail_cnt++;
      end else begin
        e = page_results_q.pop_front();
        cmp_field("kind", e.kind, kind_o);
        cmp_field("payload_byte", e.payload_byte, payload_byte_o);
        cmp_field("end_of_packet", e.end_of_packet, end_of_packet_o);
        cmp_field("status", e.status, status_o);
        cmp_field("granule_pos", e.granule_pos, granule_pos_o);
        cmp_field("stream_serial", e.stream_serial, stream_serial_o);
        cmp_field("page_sequence", e.page_sequence, page_sequence_o);
        cmp_field("packet_count", e.packet_count, packet_count_o);
        cmp_field("body_len", e.body_len, body_len_o);
        cmp_field("last_of_run", e.last_of_run, last_of_run_o);
      end
    end
  end

  // Watchdog
  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("ogg_page_checker_top_tb failed");
      $finish;
    end
  end

  initial begin
    walker_reset();
    // Directed table: truncations in the header and noise after them.
    dir_rows = '{
      '{8'h4F, 1'b1, 1'b1, ST_TRUNC},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b1, 1'b1, ST_TRUNC},
      '{8'h4F, 1'b0, 1'b0, ST_OK},
      '{8'h67, 1'b0, 1'b0, ST_OK},
      '{8'h67, 1'b0, 1'b0, ST_OK},
      '{8'h53, 1'b1, 1'b1, ST_TRUNC},
      '{8'hAA, 1'b0, 1'b0, ST_OK},
      '{8'h55, 1'b1, 1'b1, ST_TRUNC}
    };
    foreach (dir_rows[i]) begin
      stim_byte_q.insert(stim_byte_q.size(), dir_rows[i].d);
      stim_last_q.insert(stim_last_q.size(), dir_rows[i].l);
      dir_chk_q.insert(dir_chk_q.size(), dir_rows[i].chk);
      dir_st_q.insert(dir_st_q.size(), dir_rows[i].st);
    end
    // one stream of each kind, good and broken
    for (int m = 0; m < MD_COUNT; m++) queue_stream(stream_mode_e'(m));
    // random part: mostly clean streams, the rest broken or noise
    while (stim_byte_q.size() < ItemTarget) begin
      if ($urandom_range(0, 99) < 60) queue_stream(MD_GOOD);
      else queue_stream(stream_mode_e'($urandom_range(1, MD_COUNT - 1)));
    end
    total_items = stim_byte_q.size();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && !in_valid_i);
    wait (page_results_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && page_results_q.size() == 0) begin
      $display("ogg_page_checker_top_tb passed");
    end else begin
      $display("ogg_page_checker_top_tb failed");
    end
    $finish;
  end

endmodule
